>>> rtl/aabb_build_transform_union_macros.svh
// Assertion macros shared by the checker of aabb_build_transform_union.
// Depends on signals named clk and rst_n in the scope of each use.
`ifndef AABB_BUILD_TRANSFORM_UNION_MACROS_SVH
`define AABB_BUILD_TRANSFORM_UNION_MACROS_SVH

// Antecedent implies consequent; the consequent may start with a delay.
`define ABTU_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("abtu check failed");

// Expression holds at every clock edge outside reset.
`define ABTU_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("abtu invariant failed");

`endif

>>> rtl/abtu_pkg.sv
// Package for the box transform/union block: widths, request and response
// types, opcodes and fixed-point helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package abtu_pkg;

    localparam int VAL_W         = 32;
    localparam int COORD_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int AXES          = 3;
    localparam int COLS          = 4;
    localparam int MAT_N         = AXES * COLS;
    localparam int LANES         = AXES * AXES;
    localparam int FULL_W        = 2 * VAL_W;
    localparam int PROD_W        = FULL_W - FRACTION_BITS;
    localparam int SUM_W         = PROD_W + 2;

    typedef logic signed [VAL_W-1:0]       abtu_val_t;
    typedef logic signed [COORD_WIDTH-1:0] abtu_coord_t;
    typedef logic signed [PROD_W-1:0]      abtu_prod_t;
    typedef logic signed [SUM_W-1:0]       abtu_sum_t;

    // Saturation limits of the coordinate range, held at sum width
    localparam abtu_sum_t SAT_HI = SUM_W'((65'sd1 <<< (COORD_WIDTH - 1)) - 65'sd1);
    localparam abtu_sum_t SAT_LO = ~SAT_HI;

    typedef enum logic [1:0] {
        OP_LOAD_ROW = 2'd0,
        OP_VERTEX   = 2'd1,
        OP_UPDATE   = 2'd2
    } abtu_op_t;

    typedef struct packed {
        abtu_op_t   opcode;
        logic [1:0] row;
        abtu_val_t  value_a;
        abtu_val_t  value_b;
        abtu_val_t  value_c;
        abtu_val_t  value_d;
        logic       last;
    } abtu_req_t;

    typedef struct packed {
        abtu_val_t cur_min_x;
        abtu_val_t cur_min_y;
        abtu_val_t cur_min_z;
        abtu_val_t cur_max_x;
        abtu_val_t cur_max_y;
        abtu_val_t cur_max_z;
        abtu_val_t union_min_x;
        abtu_val_t union_min_y;
        abtu_val_t union_min_z;
        abtu_val_t union_max_x;
        abtu_val_t union_max_y;
        abtu_val_t union_max_z;
    } abtu_rsp_t;

    // Transform job travelling down the pipe
    typedef struct packed {
        logic valid;
        logic upd;      // 1: shift current into previous; 0: final vertex
    } abtu_job_t;

    // Clamp an exact sum into the signed coordinate range
    function automatic abtu_coord_t sat_coord(input abtu_sum_t s);
        abtu_sum_t t;
        t = s;
        if (s > SAT_HI)
        begin
            t = SAT_HI;
        end
        else if (s < SAT_LO)
        begin
            t = SAT_LO;
        end
        return t[COORD_WIDTH-1:0];
    endfunction

    // Coordinate to output field: sign-extend, then keep the low bits
    function automatic abtu_val_t coord_to_out(input abtu_coord_t c);
        abtu_sum_t w;
        w = abtu_sum_t'(c);
        return w[VAL_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/abtu_front.sv
// Request stage: holds the 3x4 transform and the local box, and issues
// transform jobs. Depends on abtu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module abtu_front (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 accept,
    input  abtu_pkg::abtu_req_t req,
    output abtu_pkg::abtu_val_t mat  [abtu_pkg::MAT_N],
    output abtu_pkg::abtu_val_t lmin [abtu_pkg::AXES],
    output abtu_pkg::abtu_val_t lmax [abtu_pkg::AXES],
    output abtu_pkg::abtu_job_t job
);
    import abtu_pkg::*;

    abtu_val_t mat_reg  [MAT_N];
    abtu_val_t mat_next [MAT_N];
    abtu_val_t lmin_reg [AXES];
    abtu_val_t lmin_next[AXES];
    abtu_val_t lmax_reg [AXES];
    abtu_val_t lmax_next[AXES];
    logic      fresh_reg;
    logic      fresh_next;
    abtu_job_t job_reg;
    abtu_job_t job_next;
    abtu_val_t vin[COLS];

    assign vin[0] = req.value_a;
    assign vin[1] = req.value_b;
    assign vin[2] = req.value_c;
    assign vin[3] = req.value_d;

    // State update for one request
    always_comb
    begin
        mat_next   = mat_reg;
        lmin_next  = lmin_reg;
        lmax_next  = lmax_reg;
        fresh_next = fresh_reg;
        job_next   = '0;
        if (accept)
        begin
            case (req.opcode)
                OP_LOAD_ROW:
                begin
                    // row 3 matches no row and is dropped
                    for (int r = 0; r < AXES; r++)
                    begin
                        if (req.row == 2'(r))
                        begin
                            for (int c = 0; c < COLS; c++)
                            begin
                                mat_next[r*COLS+c] = vin[c];
                            end
                        end
                    end
                end
                OP_VERTEX:
                begin
                    for (int i = 0; i < AXES; i++)
                    begin
                        if (fresh_reg || vin[i] < lmin_reg[i])
                        begin
                            lmin_next[i] = vin[i];
                        end
                        if (fresh_reg || vin[i] > lmax_reg[i])
                        begin
                            lmax_next[i] = vin[i];
                        end
                    end
                    fresh_next     = req.last;
                    job_next.valid = req.last;
                    job_next.upd   = 1'b0;
                end
                OP_UPDATE:
                begin
                    job_next.valid = 1'b1;
                    job_next.upd   = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAT_N; k++)
            begin
                mat_reg[k] <= '0;
            end
            for (int i = 0; i < AXES; i++)
            begin
                lmin_reg[i] <= '0;
                lmax_reg[i] <= '0;
            end
            fresh_reg <= 1'b1;
            job_reg   <= '0;
        end
        else
        begin
            mat_reg   <= mat_next;
            lmin_reg  <= lmin_next;
            lmax_reg  <= lmax_next;
            fresh_reg <= fresh_next;
            job_reg   <= job_next;
        end
    end

    assign mat  = mat_reg;
    assign lmin = lmin_reg;
    assign lmax = lmax_reg;
    assign job  = job_reg;

endmodule

`default_nettype wire

>>> rtl/abtu_mul.sv
// Product stage: nine multiplier lanes, each scaling one local min and max
// by a matrix coefficient (Q16.16, floor shift). Depends on abtu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module abtu_mul (
    input  wire                  clk,
    input  wire                  rst_n,
    input  abtu_pkg::abtu_val_t  mat  [abtu_pkg::MAT_N],
    input  abtu_pkg::abtu_val_t  lmin [abtu_pkg::AXES],
    input  abtu_pkg::abtu_val_t  lmax [abtu_pkg::AXES],
    input  abtu_pkg::abtu_job_t  job_in,
    output abtu_pkg::abtu_prod_t p    [abtu_pkg::LANES],
    output abtu_pkg::abtu_prod_t q    [abtu_pkg::LANES],
    output abtu_pkg::abtu_val_t  trans[abtu_pkg::AXES],
    output abtu_pkg::abtu_job_t  job_out
);
    import abtu_pkg::*;

    logic signed [FULL_W-1:0] pf[LANES];
    logic signed [FULL_W-1:0] qf[LANES];
    abtu_prod_t p_reg    [LANES];
    abtu_prod_t p_next   [LANES];
    abtu_prod_t q_reg    [LANES];
    abtu_prod_t q_next   [LANES];
    abtu_val_t  trans_reg [AXES];
    abtu_val_t  trans_next[AXES];
    abtu_job_t  job_reg;

    // One lane per (row, column): full product, then drop the fraction bits
    always_comb
    begin
        for (int r = 0; r < AXES; r++)
        begin
            for (int c = 0; c < AXES; c++)
            begin
                pf[r*AXES+c]     = mat[r*COLS+c] * lmin[c];
                qf[r*AXES+c]     = mat[r*COLS+c] * lmax[c];
                p_next[r*AXES+c] = pf[r*AXES+c][FULL_W-1:FRACTION_BITS];
                q_next[r*AXES+c] = qf[r*AXES+c][FULL_W-1:FRACTION_BITS];
            end
            trans_next[r] = mat[r*COLS+COLS-1];
        end
    end

    // Product registers carry no reset
    always_ff @(posedge clk)
    begin
        p_reg     <= p_next;
        q_reg     <= q_next;
        trans_reg <= trans_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_reg <= '0;
        end
        else
        begin
            job_reg <= job_in;
        end
    end

    assign p       = p_reg;
    assign q       = q_reg;
    assign trans   = trans_reg;
    assign job_out = job_reg;

endmodule

`default_nettype wire

>>> rtl/abtu_reduce.sv
// Sum stage: per-term min/max, row sums with translation, saturation, and
// the current/previous world boxes. Depends on abtu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module abtu_reduce (
    input  wire                   clk,
    input  wire                   rst_n,
    input  abtu_pkg::abtu_prod_t  p    [abtu_pkg::LANES],
    input  abtu_pkg::abtu_prod_t  q    [abtu_pkg::LANES],
    input  abtu_pkg::abtu_val_t   trans[abtu_pkg::AXES],
    input  abtu_pkg::abtu_job_t   job,
    output abtu_pkg::abtu_coord_t cur_min [abtu_pkg::AXES],
    output abtu_pkg::abtu_coord_t cur_max [abtu_pkg::AXES],
    output abtu_pkg::abtu_coord_t prev_min[abtu_pkg::AXES],
    output abtu_pkg::abtu_coord_t prev_max[abtu_pkg::AXES],
    output logic                  fire
);
    import abtu_pkg::*;

    abtu_sum_t   lo[AXES];
    abtu_sum_t   hi[AXES];
    abtu_coord_t new_min[AXES];
    abtu_coord_t new_max[AXES];
    abtu_coord_t cur_min_reg  [AXES];
    abtu_coord_t cur_max_reg  [AXES];
    abtu_coord_t prev_min_reg [AXES];
    abtu_coord_t prev_max_reg [AXES];
    abtu_coord_t prev_min_next[AXES];
    abtu_coord_t prev_max_next[AXES];
    logic        fire_reg;

    // Corner min/max: separable, so sum the per-term extremes
    always_comb
    begin
        for (int r = 0; r < AXES; r++)
        begin
            lo[r] = abtu_sum_t'(trans[r]);
            hi[r] = abtu_sum_t'(trans[r]);
            for (int c = 0; c < AXES; c++)
            begin
                lo[r] = lo[r] + abtu_sum_t'((p[r*AXES+c] < q[r*AXES+c]) ?
                                            p[r*AXES+c] : q[r*AXES+c]);
                hi[r] = hi[r] + abtu_sum_t'((p[r*AXES+c] > q[r*AXES+c]) ?
                                            p[r*AXES+c] : q[r*AXES+c]);
            end
            new_min[r] = sat_coord(lo[r]);
            new_max[r] = sat_coord(hi[r]);
            // Update keeps the old current; a final vertex resets both boxes
            prev_min_next[r] = job.upd ? cur_min_reg[r] : new_min[r];
            prev_max_next[r] = job.upd ? cur_max_reg[r] : new_max[r];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                cur_min_reg[i]  <= '0;
                cur_max_reg[i]  <= '0;
                prev_min_reg[i] <= '0;
                prev_max_reg[i] <= '0;
            end
            fire_reg <= 1'b0;
        end
        else
        begin
            if (job.valid)
            begin
                cur_min_reg  <= new_min;
                cur_max_reg  <= new_max;
                prev_min_reg <= prev_min_next;
                prev_max_reg <= prev_max_next;
            end
            fire_reg <= job.valid;
        end
    end

    assign cur_min  = cur_min_reg;
    assign cur_max  = cur_max_reg;
    assign prev_min = prev_min_reg;
    assign prev_max = prev_max_reg;
    assign fire     = fire_reg;

endmodule

`default_nettype wire

>>> rtl/abtu_emit.sv
// Result stage: forms current and union boxes from the stored boxes and
// holds them in the result register. Depends on abtu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module abtu_emit (
    input  wire                   clk,
    input  wire                   rst_n,
    input  abtu_pkg::abtu_coord_t cur_min [abtu_pkg::AXES],
    input  abtu_pkg::abtu_coord_t cur_max [abtu_pkg::AXES],
    input  abtu_pkg::abtu_coord_t prev_min[abtu_pkg::AXES],
    input  abtu_pkg::abtu_coord_t prev_max[abtu_pkg::AXES],
    input  wire                   fire,
    output logic                  done,
    output abtu_pkg::abtu_rsp_t   rsp
);
    import abtu_pkg::*;

    abtu_coord_t umin[AXES];
    abtu_coord_t umax[AXES];
    abtu_rsp_t   rsp_reg;
    abtu_rsp_t   rsp_next;
    logic        done_reg;

    // Union of previous and current, per axis
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            umin[i] = (prev_min[i] < cur_min[i]) ? prev_min[i] : cur_min[i];
            umax[i] = (prev_max[i] > cur_max[i]) ? prev_max[i] : cur_max[i];
        end
        rsp_next.cur_min_x   = coord_to_out(cur_min[0]);
        rsp_next.cur_min_y   = coord_to_out(cur_min[1]);
        rsp_next.cur_min_z   = coord_to_out(cur_min[2]);
        rsp_next.cur_max_x   = coord_to_out(cur_max[0]);
        rsp_next.cur_max_y   = coord_to_out(cur_max[1]);
        rsp_next.cur_max_z   = coord_to_out(cur_max[2]);
        rsp_next.union_min_x = coord_to_out(umin[0]);
        rsp_next.union_min_y = coord_to_out(umin[1]);
        rsp_next.union_min_z = coord_to_out(umin[2]);
        rsp_next.union_max_x = coord_to_out(umax[0]);
        rsp_next.union_max_y = coord_to_out(umax[1]);
        rsp_next.union_max_z = coord_to_out(umax[2]);
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fire;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

>>> rtl/aabb_build_transform_union.sv
// Top level of the axis-aligned box transform/union block.
// Depends on abtu_pkg, abtu_front, abtu_mul, abtu_reduce, abtu_emit.
//
// A request is taken on every clock edge where start is high; busy stays
// low, so one request per cycle is sustained for any opcode mix. Matrix
// rows and vertices update state at the accepting edge. A final vertex or
// an update request yields one response on rsp, flagged by done for
// exactly one cycle; done and rsp are loaded at the same edge. In order,
// the path registers the request into the stored matrix, local box and
// job; the products of the nine parallel 32x32 multiplier lanes; the
// min/max row sums with saturation into the stored boxes; and the union
// in the result register. Responses come out in request order and cannot
// be held off, so the receiver must take rsp whenever done is high.
`timescale 1ns / 1ps
`default_nettype none

module aabb_build_transform_union (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    output logic                busy,
    input  abtu_pkg::abtu_req_t req,
    output logic                done,
    output abtu_pkg::abtu_rsp_t rsp
);
    import abtu_pkg::*;

    logic        accept;
    abtu_val_t   mat  [MAT_N];
    abtu_val_t   lmin [AXES];
    abtu_val_t   lmax [AXES];
    abtu_job_t   job_front;
    abtu_job_t   job_mul;
    abtu_prod_t  p    [LANES];
    abtu_prod_t  q    [LANES];
    abtu_val_t   trans[AXES];
    abtu_coord_t cur_min [AXES];
    abtu_coord_t cur_max [AXES];
    abtu_coord_t prev_min[AXES];
    abtu_coord_t prev_max[AXES];
    logic        fire;

    // Fully pipelined: never stalls the sender
    assign busy   = 1'b0;
    assign accept = start && !busy;

    abtu_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (req),
        .mat    (mat),
        .lmin   (lmin),
        .lmax   (lmax),
        .job    (job_front)
    );

    abtu_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .mat     (mat),
        .lmin    (lmin),
        .lmax    (lmax),
        .job_in  (job_front),
        .p       (p),
        .q       (q),
        .trans   (trans),
        .job_out (job_mul)
    );

    abtu_reduce u_reduce (
        .clk      (clk),
        .rst_n    (rst_n),
        .p        (p),
        .q        (q),
        .trans    (trans),
        .job      (job_mul),
        .cur_min  (cur_min),
        .cur_max  (cur_max),
        .prev_min (prev_min),
        .prev_max (prev_max),
        .fire     (fire)
    );

    abtu_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .cur_min  (cur_min),
        .cur_max  (cur_max),
        .prev_min (prev_min),
        .prev_max (prev_max),
        .fire     (fire),
        .done     (done),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire

>>> rtl/abtu_checker.sv
// Port-level checker for aabb_build_transform_union, bound to the top level.
// Depends on abtu_pkg and aabb_build_transform_union_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "aabb_build_transform_union_macros.svh"

module abtu_checker (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 start,
    input wire                 busy,
    input abtu_pkg::abtu_req_t req,
    input wire                 done,
    input abtu_pkg::abtu_rsp_t rsp
);
    import abtu_pkg::*;

    logic taken;

    // Request handshake
    assign taken = start && !busy;

    // An update request always yields a response flagged by done
    `ABTU_ASSERT_IMPLY(a_update_answers, taken && req.opcode == OP_UPDATE, ##4 done)

    // The final vertex of a mesh also yields a response
    `ABTU_ASSERT_IMPLY(a_last_vertex_answers, taken && req.opcode == OP_VERTEX && req.last, ##4 done)

    // Matrix loads never produce a response
    `ABTU_ASSERT_IMPLY(a_row_silent, taken && req.opcode == OP_LOAD_ROW, ##4 !done)

    // Every response traces back to an earlier taken request
    `ABTU_ASSERT_IMPLY(a_done_traced, done, $past(taken, 4))

    // While done is high, the union box encloses the current box in min x
    `ABTU_ASSERT_ALWAYS(a_union_covers, !done || rsp.union_min_x <= rsp.cur_min_x)

endmodule

bind aabb_build_transform_union abtu_checker u_abtu_checker (.*);

`default_nettype wire
